[rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants for the pressure compensation block
// Register indexes, calibration constants and the divider request record.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_COEFFS  = 2'd0,
    REG_PRESS_A      = 2'd1,
    REG_PRESS_B      = 2'd2,
    REG_OVERSAMPLING = 2'd3
  } cfg_reg_t;

  localparam logic signed [31:0] B6Offset   = 32'sd4000;
  localparam logic signed [31:0] B4Offset   = 32'sd32768;
  localparam logic [31:0]        B7Scale    = 32'd50000;
  localparam logic signed [31:0] PressC1    = 32'sd3038;
  localparam logic signed [31:0] PressC2    = -32'sd7357;
  localparam logic signed [31:0] PressC3    = 32'sd3791;
  localparam logic [31:0]        SignBit    = 32'h8000_0000;

  // Divider request: dividend magnitude, divisor magnitude, sign fixup
  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        neg;
  } div_req_t;

endpackage

[rtl/bpc_if.sv]
// ----------------------------------------------------------------------------
// bpc_stream_if: valid/ready channel carrying one payload item
// Payload type is a parameter so input and output channels share the file.
// ----------------------------------------------------------------------------
interface bpc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/baro_pressure_compensation_top.sv]
// Throughput: one item per cycle unless stalled; two 8-stage dividers set the
// pipeline depth. The whole pipeline advances together and holds when the output
// stage is full and not taken. Reset (rst, synchronous) clears all valid bits and
// zeroes the configuration registers; payload registers are not reset.
// ----------------------------------------------------------------------------
// baro_pressure_compensation_top: temperature and pressure compensation
// Integer datasheet steps in 32-bit wrap arithmetic, fully pipelined.
// ----------------------------------------------------------------------------
module baro_pressure_compensation_top #(
  parameter int unsigned DivSteps = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [bpc_pkg::CfgDataW-1:0]   cfg_wdata,
  bpc_stream_if.sink                     in_ch,
  bpc_stream_if.source                   out_ch
);
  localparam int unsigned Depth = 9 + 2 * (32 / DivSteps);

  logic [63:0] temp_coeffs, press_a;
  logic [31:0] press_b;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_a <= '0;
      press_b <= '0;
      oss <= '0;
    end else if (cfg_we) begin
      unique case (bpc_pkg::cfg_reg_t'(cfg_index))
        bpc_pkg::REG_TEMP_COEFFS:  temp_coeffs <= cfg_wdata;
        bpc_pkg::REG_PRESS_A:      press_a <= cfg_wdata;
        bpc_pkg::REG_PRESS_B:      press_b <= cfg_wdata[31:0];
        bpc_pkg::REG_OVERSAMPLING: oss <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  wire signed [31:0] ac5 = {16'd0, temp_coeffs[15:0]};
  wire signed [31:0] ac6 = {16'd0, temp_coeffs[31:16]};
  wire signed [31:0] mc  = {{16{temp_coeffs[47]}}, temp_coeffs[47:32]};
  wire signed [31:0] md  = {{16{temp_coeffs[63]}}, temp_coeffs[63:48]};
  wire signed [31:0] ac1 = {{16{press_a[15]}}, press_a[15:0]};
  wire signed [31:0] ac2 = {{16{press_a[31]}}, press_a[31:16]};
  wire signed [31:0] ac3 = {{16{press_a[47]}}, press_a[47:32]};
  wire        [31:0] ac4 = {16'd0, press_a[63:48]};
  wire signed [31:0] b1  = {{16{press_b[15]}}, press_b[15:0]};
  wire signed [31:0] b2  = {{16{press_b[31]}}, press_b[31:16]};

  // Global advance: hold everything while the output register is stuck
  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic [Depth-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], in_ch.valid};
  end

  // ---- stage 1: UT - AC6 times AC5
  logic [18:0] up1;
  logic signed [31:0] m1;
  always_ff @(posedge clk) if (adv) begin
    up1 <= in_ch.data.raw_press;
    m1 <= ($signed({16'd0, in_ch.data.raw_temp}) - ac6) * ac5;
  end

  // ---- stage 2: X1, denominator, temperature dividend
  logic [18:0] up2;
  logic signed [31:0] x1t2, den2;
  always_ff @(posedge clk) if (adv) begin
    up2 <= up1;
    x1t2 <= m1 >>> 15;
    den2 <= (m1 >>> 15) + md;
  end

  typedef struct packed {
    logic [18:0] up;
    logic signed [31:0] x1;
    logic fault;
  } tside_t;

  bpc_pkg::div_req_t treq;
  tside_t tside_in, tside_o;
  logic signed [31:0] tnum;
  assign tnum = mc <<< 11;
  always_comb begin
    treq.num = tnum[31] ? 32'(-tnum) : tnum;
    treq.den = den2[31] ? 32'(-den2) : den2;
    treq.neg = tnum[31] ^ den2[31];
    tside_in = '{up: up2, x1: x1t2, fault: den2 == 32'sd0};
  end

  logic [31:0] tq;
  logic tneg;
  bpc_divpipe #(.Steps(DivSteps), .side_t(tside_t)) u_tdiv (
    .clk, .en(adv), .req(treq), .side_in(tside_in),
    .quot(tq), .neg(tneg), .side_out(tside_o)
  );

  // ---- B5, T, B6
  logic signed [31:0] b6a, ta;
  logic [18:0] upa;
  logic fa;
  always_ff @(posedge clk) if (adv) begin
    b6a <= tside_o.x1 + (tneg ? 32'(-tq) : tq) - bpc_pkg::B6Offset;
    ta <= $signed(tside_o.x1 + (tneg ? 32'(-tq) : tq) + 32'sd8) >>> 4;
    upa <= tside_o.up;
    fa <= tside_o.fault;
  end

  // ---- B6 squared, AC2*B6, AC3*B6
  logic signed [31:0] sqm, ac2m, ac3m, tb;
  logic [18:0] upb;
  logic fb;
  always_ff @(posedge clk) if (adv) begin
    sqm <= b6a * b6a;
    ac2m <= ac2 * b6a;
    ac3m <= ac3 * b6a;
    tb <= ta; upb <= upa; fb <= fa;
  end

  // ---- B2*SQ, B1*SQ
  logic signed [31:0] b2m, b1m, ac2s, ac3s, tc;
  logic [18:0] upc;
  logic fc;
  always_ff @(posedge clk) if (adv) begin
    b2m <= b2 * (sqm >>> 12);
    b1m <= b1 * (sqm >>> 12);
    ac2s <= ac2m >>> 11;
    ac3s <= ac3m >>> 13;
    tc <= tb; upc <= upb; fc <= fb;
  end

  // ---- B3 and X3 for B4
  logic signed [31:0] b3d, x3d, td, b3s, b3n;
  logic [18:0] upd;
  logic fd;
  always_comb begin
    b3s = ((ac1 * 32'sd4 + (b2m >>> 11) + ac2s) <<< oss) + 32'sd2;
    // truncating divide by four
    b3n = (b3s + (b3s[31] ? 32'sd3 : 32'sd0)) >>> 2;
  end
  always_ff @(posedge clk) if (adv) begin
    b3d <= b3n;
    x3d <= (((ac3s + (b1m >>> 16)) + 32'sd2) >>> 2) + bpc_pkg::B4Offset;
    td <= tc; upd <= upc; fd <= fc;
  end

  // ---- B4 and B7 products
  logic [31:0] b4e, b7e;
  logic signed [31:0] te;
  logic fe;
  always_ff @(posedge clk) if (adv) begin
    b4e <= ac4 * x3d;
    b7e <= ({13'd0, upd} - b3d) * (bpc_pkg::B7Scale >> oss);
    te <= td; fe <= fd;
  end

  typedef struct packed {
    logic signed [31:0] t;
    logic fault;
    logic hi;
  } pside_t;

  logic [31:0] b4f;
  bpc_pkg::div_req_t preq;
  pside_t pside_in, pside_o;
  assign b4f = {15'd0, b4e[31:15]};
  always_comb begin
    preq.num = b7e[31] ? b7e : {b7e[30:0], 1'b0};
    preq.den = b4f;
    preq.neg = 1'b0;
    pside_in = '{t: te, fault: fe || (b4f == 32'd0), hi: b7e[31]};
  end

  logic [31:0] pq;
  logic pneg;
  bpc_divpipe #(.Steps(DivSteps), .side_t(pside_t)) u_pdiv (
    .clk, .en(adv), .req(preq), .side_in(pside_in),
    .quot(pq), .neg(pneg), .side_out(pside_o)
  );

  // ---- final correction terms
  logic signed [31:0] pg, sg, x2g, tg;
  logic fg;
  always_ff @(posedge clk) if (adv) begin
    pg <= pside_o.hi ? {pq[30:0], 1'b0} : pq;
    sg <= ($signed(pside_o.hi ? {pq[30:0], 1'b0} : pq) >>> 8)
        * ($signed(pside_o.hi ? {pq[30:0], 1'b0} : pq) >>> 8);
    x2g <= bpc_pkg::PressC2 * (pside_o.hi ? $signed({pq[30:0], 1'b0}) : $signed(pq));
    tg <= pside_o.t; fg <= pside_o.fault || pneg;
  end

  logic signed [31:0] ph, x1h, x2h, th;
  logic fh;
  always_ff @(posedge clk) if (adv) begin
    ph <= pg;
    x1h <= (sg * bpc_pkg::PressC1) >>> 16;
    x2h <= x2g >>> 16;
    th <= tg; fh <= fg;
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= vld[Depth-1];
    end
  end
  always_ff @(posedge clk) if (adv) begin
    out_ch.data.divide_fault <= fh;
    out_ch.data.temp_tenths <= fh ? 32'sd0 : th;
    out_ch.data.pressure_pa <= fh ? 32'sd0 :
      ph + ((x1h + x2h + bpc_pkg::PressC3) >>> 4);
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.divide_fault |->
    out_ch.data.pressure_pa == 32'sd0 && out_ch.data.temp_tenths == 32'sd0)
    else $error("fault result not zero");
  a_stall_vld: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while stalled");
`endif
endmodule

[rtl/bpc_divpipe.sv]
// ----------------------------------------------------------------------------
// bpc_divpipe: pipelined 32-bit unsigned restoring divider
// One quotient bit per step, Steps steps per register stage; stall by en.
// ----------------------------------------------------------------------------
module bpc_divpipe #(
  parameter int unsigned Steps = 4,
  parameter type side_t = logic
) (
  input  logic                clk,
  input  logic                en,
  input  bpc_pkg::div_req_t   req,
  input  side_t               side_in,
  output logic [31:0]         quot,
  output logic                neg,
  output side_t               side_out
);
  localparam int unsigned Stages = 32 / Steps;

  logic [31:0] rem_q [Stages+1];
  logic [31:0] num_q [Stages+1];
  logic [31:0] den_q [Stages+1];
  logic        neg_q [Stages+1];
  side_t       side_q [Stages+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = req.num;
    den_q[0] = req.den;
    neg_q[0] = req.neg;
    side_q[0] = side_in;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [31:0] rem_c;
    logic [31:0] num_c;
    logic [32:0] trial;
    always_comb begin
      rem_c = rem_q[s];
      num_c = num_q[s];
      for (int k = 0; k < Steps; k++) begin
        trial = {rem_c, num_c[31]};
        num_c = {num_c[30:0], 1'b0};
        if (trial >= {1'b0, den_q[s]}) begin
          trial = trial - {1'b0, den_q[s]};
          num_c[0] = 1'b1;
        end
        rem_c = trial[31:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= rem_c;
        num_q[s+1] <= num_c;
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign quot = num_q[Stages];
  assign neg = neg_q[Stages];
  assign side_out = side_q[Stages];
endmodule
